### hdl/hbh_pkg.sv
`default_nettype none

package hbh_pkg;

   localparam int HUE_W             = 15;
   localparam int MODE_W            = 3;
   localparam int CSR_IDX_W         = 2;
   localparam int HUE_FRAC_BITS_DEF = 6;
   localparam int NUM_BANDS         = 4;
   localparam int BAND_IDX_W        = $clog2(NUM_BANDS);
   localparam int BAND_CNT_W        = $clog2(NUM_BANDS + 1);
   localparam int DEG_W             = 9;
   localparam int DEG_FULL          = 360;

   // floor(v / 360) for 15-bit v by reciprocal multiply
   localparam int DIV360_K = 23;
   localparam int DIV360_M = 23302;
   localparam int Q360_W   = 7;
   localparam int P360_W   = HUE_W + DIV360_K;

   // offset quotient: ((mag * width + full / 2) >> frac) / 8 / 45
   localparam int VAL_W   = 23;
   localparam int NQ_W    = VAL_W - 3;
   localparam int SPLIT_W = 10;
   localparam int DIV45_K = 26;
   localparam int DIV45_M = 1491309;
   localparam int M45_W   = 21;
   localparam int PP_W    = SPLIT_W + M45_W;
   localparam int SUM_W   = PP_W + SPLIT_W + 1;
   localparam int OFF_W   = 15;
   localparam int OFF_MAX = 16384;

   localparam logic [MODE_W-1:0] MODE_ANALOGOUS      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MONOCHROME     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_COMPLEMENTARY  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SPLIT_COMPLEM  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TRIADIC        = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SQUARE         = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_HARMONY_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_HUE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_WIDTH = 2'd2;

   localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
   localparam logic [DEG_W-1:0] DEG_120 = 9'd120;
   localparam logic [DEG_W-1:0] DEG_150 = 9'd150;
   localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
   localparam logic [DEG_W-1:0] DEG_210 = 9'd210;
   localparam logic [DEG_W-1:0] DEG_240 = 9'd240;
   localparam logic [DEG_W-1:0] DEG_270 = 9'd270;

   typedef struct packed {
      logic first;
      logic second;
   } stage_en_type;

   function automatic int hue_bits(input int frac);
      return $clog2(DEG_FULL << frac);
   endfunction

   function automatic logic [BAND_CNT_W-1:0] band_count(input logic [MODE_W-1:0] mode);
      logic [BAND_CNT_W-1:0] cnt;
      case (mode)
         MODE_COMPLEMENTARY: cnt = BAND_CNT_W'(2);
         MODE_SPLIT_COMPLEM: cnt = BAND_CNT_W'(3);
         MODE_TRIADIC:       cnt = BAND_CNT_W'(3);
         MODE_SQUARE:        cnt = BAND_CNT_W'(4);
         default:            cnt = BAND_CNT_W'(1);
      endcase
      return cnt;
   endfunction

   function automatic logic [DEG_W-1:0] band_deg(input logic [MODE_W-1:0] mode,
                                                  input logic [BAND_IDX_W-1:0] k);
      logic [DEG_W-1:0] deg;
      deg = '0;
      case (mode)
         MODE_COMPLEMENTARY: begin
            if (k == BAND_IDX_W'(1)) deg = DEG_180;
         end
         MODE_SPLIT_COMPLEM: begin
            if (k == BAND_IDX_W'(1)) deg = DEG_150;
            if (k == BAND_IDX_W'(2)) deg = DEG_210;
         end
         MODE_TRIADIC: begin
            if (k == BAND_IDX_W'(1)) deg = DEG_120;
            if (k == BAND_IDX_W'(2)) deg = DEG_240;
         end
         MODE_SQUARE: begin
            if (k == BAND_IDX_W'(1)) deg = DEG_90;
            if (k == BAND_IDX_W'(2)) deg = DEG_180;
            if (k == BAND_IDX_W'(3)) deg = DEG_270;
         end
         default: deg = '0;
      endcase
      return deg;
   endfunction

   function automatic logic [Q360_W-1:0] div360(input logic [HUE_W-1:0] v);
      logic [P360_W-1:0] p;
      p = P360_W'(v) * P360_W'(DIV360_M);
      return p[DIV360_K +: Q360_W];
   endfunction

endpackage

`default_nettype wire

### hdl/hbh_if.sv
`default_nettype none

interface hbh_req_if import hbh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  pixel_hue;
   logic              last_in_frame;

   modport source (output valid, output pixel_hue, output last_in_frame, input ready);
   modport sink   (input valid, input pixel_hue, input last_in_frame, output ready);
endinterface

interface hbh_rsp_if import hbh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  new_hue;
   logic              frame_end;

   modport source (output valid, output new_hue, output frame_end, input ready);
   modport sink   (input valid, input new_hue, input frame_end, output ready);
endinterface

interface hbh_csr_if import hbh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [HUE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/hue_band_harmonizer.sv
// hue_band_harmonizer: pulls each pixel hue toward the nearest band of a
// harmony template set up through the csr channel.
// req channel: one pixel hue and a last-in-frame flag per transfer.
// rsp channel: the harmonized hue and the frame-end flag, one per request,
// in request order.
// csr channel: index 0 mode, 1 main hue, 2 surface width; always ready.
// Write it only while no pixel is in flight.
// Throughput: one pixel per clock while rsp is not stalled, set by the 12-stage
// pipeline; every stage holds one pixel and moves on when the stage after it is free.
// When the receiver stalls, rsp holds its result and the pipeline keeps
// taking pixels until every stage holds one; bubbles are squeezed out.
// Reset empties the pipeline and clears all three csr registers to 0.
// No memories, so there is no clearing pass after reset.
`default_nettype none

module hue_band_harmonizer import hbh_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hbh_req_if.sink    req_bus,
   hbh_rsp_if.source  rsp_bus,
   hbh_csr_if.sink    csr_bus
);

   localparam int FULL   = DEG_FULL << HUE_FRAC_BITS;
   localparam int HW     = hue_bits(HUE_FRAC_BITS);
   localparam int HALF   = FULL / 2;
   localparam int MAG_W  = $clog2(HALF + 1);
   localparam int PROD_W = MAG_W + HUE_W;

   localparam logic [HW:0]       FULL_V = (HW + 1)'(FULL);
   localparam logic [HW-1:0]     HALF_H = HW'(HALF);
   localparam logic [MAG_W-1:0]  HALF_M = MAG_W'(HALF);
   localparam logic [PROD_W-1:0] HALF_P = PROD_W'(HALF);

   localparam int NSTAGE   = 12;
   localparam int ST_IN    = 0;
   localparam int ST_WRAP  = 2;
   localparam int ST_BAND  = 3;
   localparam int ST_DIST  = 4;
   localparam int ST_SEL   = 5;
   localparam int ST_PROD  = 6;
   localparam int ST_PART  = 7;
   localparam int ST_OFF   = 8;
   localparam int ST_OWRAP = 10;
   localparam int ST_OUT   = 11;

   // csr registers
   logic [MODE_W-1:0] mode_ff;
   logic [HUE_W-1:0]  main_hue_ff;
   logic [HUE_W-1:0]  width_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ANALOGOUS;
         main_hue_ff <= '0;
         width_ff    <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_HARMONY_MODE:  mode_ff     <= csr_bus.data[MODE_W-1:0];
            CSR_MAIN_HUE:      main_hue_ff <= csr_bus.data;
            CSR_SURFACE_WIDTH: width_ff    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] stage_en;

   assign stage_en[ST_OUT] = !vld_ff[ST_OUT] || rsp_bus.ready;
   assign vld_in[ST_IN]    = stage_en[ST_IN] ? req_bus.valid : vld_ff[ST_IN];

   for (genvar g = 0; g < ST_OUT; g++) begin : g_flow
      assign stage_en[g] = !vld_ff[g] || stage_en[g + 1];
      assign vld_in[g + 1] = stage_en[g + 1] ? vld_ff[g] : vld_ff[g + 1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = stage_en[ST_IN];

   // input stage
   logic [HUE_W-1:0] pix_ff;
   logic             lastc_ff [ST_IN:ST_OUT];

   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         pix_ff          <= req_bus.pixel_hue;
         lastc_ff[ST_IN] <= req_bus.last_in_frame;
      end
      for (int i = ST_IN + 1; i <= ST_OUT; i++) begin
         if (stage_en[i]) lastc_ff[i] <= lastc_ff[i - 1];
      end
   end

   // reduce pixel and anchor hues into one turn
   stage_en_type   hue_en;
   stage_en_type   off_en;
   logic [HW-1:0]  pix_r;
   logic [HW-1:0]  anchor_r;
   logic [HW-1:0]  off_r;

   assign hue_en = '{first: stage_en[ST_WRAP - 1], second: stage_en[ST_WRAP]};
   assign off_en = '{first: stage_en[ST_OWRAP - 1], second: stage_en[ST_OWRAP]};

   hbh_hue_wrap #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_pix_wrap (
      .clock   (clock),
      .en      (hue_en),
      .hue_in  (pix_ff),
      .hue_out (pix_r)
   );

   hbh_hue_wrap #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_anchor_wrap (
      .clock   (clock),
      .en      (hue_en),
      .hue_in  (main_hue_ff),
      .hue_out (anchor_r)
   );

   logic [HW-1:0] pixc_ff [ST_BAND:ST_OWRAP];

   always_ff @(posedge clock) begin
      if (stage_en[ST_BAND]) pixc_ff[ST_BAND] <= pix_r;
      for (int i = ST_BAND + 1; i <= ST_OWRAP; i++) begin
         if (stage_en[i]) pixc_ff[i] <= pixc_ff[i - 1];
      end
   end

   // band positions
   logic [HW:0]   band_sum [NUM_BANDS];
   logic [HW-1:0] band_c   [NUM_BANDS];
   logic [HW-1:0] bnd3_ff  [NUM_BANDS];

   always_comb begin
      for (int k = 0; k < NUM_BANDS; k++) begin
         band_sum[k] = {1'b0, anchor_r}
                     + ((HW + 1)'(band_deg(mode_ff, BAND_IDX_W'(k))) << HUE_FRAC_BITS);
         band_c[k] = (band_sum[k] >= FULL_V) ? HW'(band_sum[k] - FULL_V)
                                             : band_sum[k][HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_BAND]) bnd3_ff <= band_c;
   end

   // signed circular distance of the pixel to each band
   logic [HW:0]      diff_c [NUM_BANDS];
   logic [HW:0]      turn_c [NUM_BANDS];
   logic [MAG_W-1:0] mag_c  [NUM_BANDS];
   logic             neg_c  [NUM_BANDS];
   logic [HW-1:0]    bnd4_ff [NUM_BANDS];
   logic [MAG_W-1:0] mag4_ff [NUM_BANDS];
   logic             neg4_ff [NUM_BANDS];

   always_comb begin
      for (int k = 0; k < NUM_BANDS; k++) begin
         diff_c[k] = {1'b0, pixc_ff[ST_BAND]} - {1'b0, bnd3_ff[k]};
         turn_c[k] = diff_c[k][HW] ? diff_c[k] + FULL_V : diff_c[k];
         // the half-turn point counts as negative
         neg_c[k]  = turn_c[k][HW-1:0] >= HALF_H;
         mag_c[k]  = neg_c[k] ? MAG_W'(FULL_V - turn_c[k]) : MAG_W'(turn_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_DIST]) begin
         bnd4_ff <= bnd3_ff;
         mag4_ff <= mag_c;
         neg4_ff <= neg_c;
      end
   end

   // nearest band, ties keep the earlier one
   logic [BAND_CNT_W-1:0] n_bands;
   logic [HW-1:0]         sel_band;
   logic [MAG_W-1:0]      sel_mag;
   logic                  sel_neg;
   logic [MAG_W-1:0]      mag5_ff;
   logic [HW-1:0]         bandc_ff [ST_SEL:ST_OWRAP];
   logic                  negc_ff  [ST_SEL:ST_OWRAP];

   assign n_bands = band_count(mode_ff);

   always_comb begin
      sel_band = bnd4_ff[0];
      sel_mag  = mag4_ff[0];
      sel_neg  = neg4_ff[0];
      for (int k = 1; k < NUM_BANDS; k++) begin
         if (BAND_CNT_W'(k) < n_bands && mag4_ff[k] < sel_mag) begin
            sel_band = bnd4_ff[k];
            sel_mag  = mag4_ff[k];
            sel_neg  = neg4_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SEL]) begin
         mag5_ff          <= sel_mag;
         bandc_ff[ST_SEL] <= sel_band;
         negc_ff[ST_SEL]  <= sel_neg;
      end
      for (int i = ST_SEL + 1; i <= ST_OWRAP; i++) begin
         if (stage_en[i]) begin
            bandc_ff[i] <= bandc_ff[i - 1];
            negc_ff[i]  <= negc_ff[i - 1];
         end
      end
   end

   // offset = round(mag * width / full), halves up
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_sh;
   logic [NQ_W-1:0]   nq;
   logic [PP_W-1:0]   pp_hi_ff;
   logic [PP_W-1:0]   pp_lo_ff;
   logic [SUM_W-1:0]  pp_sum;
   logic [OFF_W-1:0]  off_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         prod_ff <= PROD_W'(mag5_ff) * PROD_W'(width_ff) + HALF_P;
      end
   end

   // divide by 2^frac, then by 8, then by 45 through a split reciprocal product
   assign prod_sh = prod_ff >> HUE_FRAC_BITS;
   assign nq      = prod_sh[VAL_W-1:3];

   always_ff @(posedge clock) begin
      if (stage_en[ST_PART]) begin
         pp_hi_ff <= PP_W'(nq[NQ_W-1:SPLIT_W]) * PP_W'(DIV45_M);
         pp_lo_ff <= PP_W'(nq[SPLIT_W-1:0]) * PP_W'(DIV45_M);
      end
   end

   assign pp_sum = (SUM_W'(pp_hi_ff) << SPLIT_W) + SUM_W'(pp_lo_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_OFF]) begin
         off_ff <= pp_sum[DIV45_K +: OFF_W];
      end
   end

   hbh_hue_wrap #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_off_wrap (
      .clock   (clock),
      .en      (off_en),
      .hue_in  (off_ff),
      .hue_out (off_r)
   );

   // apply the signed offset and wrap (monochrome: band itself, unknown mode: pixel)
   logic [HW:0]   up_sum;
   logic [HW:0]   dn_sum;
   logic [HW-1:0] res_in;
   logic [HW-1:0] res_ff;

   always_comb begin
      up_sum = {1'b0, bandc_ff[ST_OWRAP]} + {1'b0, off_r};
      if (up_sum >= FULL_V) up_sum = up_sum - FULL_V;
      dn_sum = {1'b0, bandc_ff[ST_OWRAP]} - {1'b0, off_r};
      if (dn_sum[HW]) dn_sum = dn_sum + FULL_V;
      case (mode_ff)
         MODE_MONOCHROME: res_in = bandc_ff[ST_OWRAP];
         MODE_ANALOGOUS, MODE_COMPLEMENTARY, MODE_SPLIT_COMPLEM,
         MODE_TRIADIC, MODE_SQUARE: begin
            res_in = negc_ff[ST_OWRAP] ? dn_sum[HW-1:0] : up_sum[HW-1:0];
         end
         default: res_in = pixc_ff[ST_OWRAP];
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) res_ff <= res_in;
   end

   assign rsp_bus.valid     = vld_ff[ST_OUT];
   assign rsp_bus.new_hue   = HUE_W'(res_ff);
   assign rsp_bus.frame_end = lastc_ff[ST_OUT];

`ifndef SYNTHESIS
   a_result_in_turn: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] |-> ({1'b0, res_ff} < FULL_V))
      else $error("harmonized hue outside one turn");

   a_mag_half_turn: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SEL] |-> (mag5_ff <= HALF_M))
      else $error("band distance above half a turn");

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OFF] |-> (off_ff <= OFF_W'(OFF_MAX)))
      else $error("offset quotient out of bound");
`endif

endmodule

`default_nettype wire

### hdl/hbh_hue_wrap.sv
`default_nettype none

// two-stage reduction of a 15-bit hue modulo 360 << frac
module hbh_hue_wrap import hbh_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire stage_en_type                        en,
   input  wire logic [HUE_W-1:0]                    hue_in,
   output logic      [hue_bits(HUE_FRAC_BITS)-1:0]  hue_out
);

   localparam int HW = hue_bits(HUE_FRAC_BITS);
   localparam logic [HUE_W-1:0] LOW_MASK = HUE_W'((1 << HUE_FRAC_BITS) - 1);

   logic [HUE_W-1:0]  whole_ff;
   logic [HUE_W-1:0]  low_ff;
   logic [Q360_W-1:0] quo_ff;
   logic [HUE_W-1:0]  whole_sh;
   logic [HUE_W-1:0]  rem_full;
   logic [HW-1:0]     hue_out_ff;

   assign whole_sh = hue_in >> HUE_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en.first) begin
         whole_ff <= whole_sh;
         low_ff   <= hue_in & LOW_MASK;
         quo_ff   <= div360(whole_sh);
      end
   end

   // remainder of the whole-degree part stays below 360
   assign rem_full = whole_ff - HUE_W'(quo_ff) * HUE_W'(DEG_FULL);

   always_ff @(posedge clock) begin
      if (en.second) begin
         hue_out_ff <= (HW'(rem_full[DEG_W-1:0]) << HUE_FRAC_BITS) | HW'(low_ff);
      end
   end

   assign hue_out = hue_out_ff;

endmodule

`default_nettype wire
